@@ rtl/lbpfm_pkg.sv @@
// Shared types and constants for the LRU buffer pool frame manager.
`default_nettype none

package lbpfm_pkg;

    localparam int TABLE_W = 16;
    localparam int PAGE_W  = 32;
    localparam int FRAME_W = 4;
    localparam int CFG_W   = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [1:0] {
        ACT_FETCH     = 2'd0,
        ACT_UNPIN     = 2'd1,
        ACT_FLUSH     = 2'd2,
        ACT_FLUSH_ALL = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        KIND_HIT      = 3'd0,
        KIND_LOAD     = 3'd1,
        KIND_WB       = 3'd2,
        KIND_DONE     = 3'd3,
        KIND_FULL     = 3'd4,
        KIND_NOTRES   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SRCH,
        ST_LOAD,
        ST_FLA,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_action              action;
        logic [TABLE_W-1:0]   req_table;
        logic [PAGE_W-1:0]    req_page;
        logic                 mark_dirty;
    } t_req;

    typedef struct packed {
        t_kind                kind;
        logic [TABLE_W-1:0]   out_table;
        logic [PAGE_W-1:0]    out_page;
        logic [FRAME_W-1:0]   frame;
        logic                 last;
    } t_result;

    // Operations broadcast from the controller to every frame cell.
    typedef struct packed {
        logic touch;
        logic drop;
        logic load;
        logic inc_pin;
        logic dec_pin;
        logic set_dirty;
        logic clr_dirty;
    } t_cell_op;

endpackage

`default_nettype wire

@@ rtl/lbpfm_cell.sv @@
// One frame cell: holds a frame's page, pin count, dirty mark and rank, and one search stage.
`default_nettype none

module lbpfm_cell
    import lbpfm_pkg::*;
#(
    parameter int POOL_FRAMES    = 16,
    parameter int PIN_COUNT_BITS = 8,
    parameter int ID             = 0,
    localparam int IW = $clog2(POOL_FRAMES)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_cell_op                  i_op,
    input  wire logic [IW-1:0]             i_tgt,
    input  wire logic [IW-1:0]             i_rank_ref,
    input  wire logic [TABLE_W-1:0]        i_table,
    input  wire logic [PAGE_W-1:0]         i_page,
    input  wire logic                      i_vf,
    input  wire logic [IW-1:0]             i_vr,
    input  wire logic [IW-1:0]             i_vi,
    input  wire logic                      i_ff,
    input  wire logic [IW-1:0]             i_fi,
    output logic                           o_vf,
    output logic [IW-1:0]                  o_vr,
    output logic [IW-1:0]                  o_vi,
    output logic                           o_ff,
    output logic [IW-1:0]                  o_fi,
    output logic                           o_valid,
    output logic [TABLE_W-1:0]             o_table,
    output logic [PAGE_W-1:0]              o_page,
    output logic [PIN_COUNT_BITS-1:0]      o_pin,
    output logic                           o_dirty,
    output logic [IW-1:0]                  o_rank,
    output logic                           o_hit
);

    localparam logic [PIN_COUNT_BITS-1:0] PIN_MAX = '1;
    localparam logic [IW-1:0] MY_IDX = IW'(ID);

    logic                      r_valid, n_valid;
    logic [TABLE_W-1:0]        r_table, n_table;
    logic [PAGE_W-1:0]         r_page, n_page;
    logic [PIN_COUNT_BITS-1:0] r_pin, n_pin;
    logic                      r_dirty, n_dirty;
    logic [IW-1:0]             r_rank, n_rank;
    logic                      r_vf, r_ff;
    logic [IW-1:0]             r_vr, r_vi, r_fi;
    logic                      sel, cand, take;

    assign sel  = (i_tgt == MY_IDX);
    assign cand = r_valid && (r_pin == '0);
    assign take = cand && (!i_vf || (r_rank > i_vr));

    always_comb begin
        n_valid = r_valid;
        n_table = r_table;
        n_page  = r_page;
        n_pin   = r_pin;
        n_dirty = r_dirty;
        n_rank  = r_rank;
        if (i_op.touch) begin
            if (sel) begin
                n_rank = '0;
            end else if (r_valid && (r_rank < i_rank_ref)) begin
                n_rank = r_rank + 1'b1;
            end
        end
        if (i_op.drop) begin
            if (sel) begin
                n_valid = 1'b0;
            end else if (r_valid && (r_rank > i_rank_ref)) begin
                n_rank = r_rank - 1'b1;
            end
        end
        if (sel) begin
            if (i_op.load) begin
                n_valid = 1'b1;
                n_table = i_table;
                n_page  = i_page;
                n_pin   = PIN_COUNT_BITS'(1);
                n_dirty = 1'b0;
            end
            if (i_op.inc_pin && (r_pin != PIN_MAX)) begin
                n_pin = r_pin + 1'b1;
            end
            if (i_op.dec_pin && (r_pin != '0)) begin
                n_pin = r_pin - 1'b1;
            end
            if (i_op.set_dirty) begin
                n_dirty = 1'b1;
            end
            if (i_op.clr_dirty) begin
                n_dirty = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pin   <= '0;
            r_dirty <= 1'b0;
            r_vf    <= 1'b0;
            r_ff    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pin   <= n_pin;
            r_dirty <= n_dirty;
            r_vf    <= i_vf || cand;
            r_ff    <= i_ff || !r_valid;
        end
    end

    // The search record moves one cell further every cycle.
    always_ff @(posedge i_clk) begin
        r_table <= n_table;
        r_page  <= n_page;
        r_rank  <= n_rank;
        r_vr    <= take ? r_rank : i_vr;
        r_vi    <= take ? MY_IDX : i_vi;
        r_fi    <= (!i_ff && !r_valid) ? MY_IDX : i_fi;
    end

    assign o_vf    = r_vf;
    assign o_vr    = r_vr;
    assign o_vi    = r_vi;
    assign o_ff    = r_ff;
    assign o_fi    = r_fi;
    assign o_valid = r_valid;
    assign o_table = r_table;
    assign o_page  = r_page;
    assign o_pin   = r_pin;
    assign o_dirty = r_dirty;
    assign o_rank  = r_rank;
    assign o_hit   = r_valid && (r_table == i_table) && (r_page == i_page);

endmodule

`default_nettype wire

@@ rtl/lru_buffer_pool_frame_manager.sv @@
// Top level of the LRU buffer pool frame manager: frame cell chain and request controller.
`default_nettype none

// A request is taken when start is high and busy is low; results come out one per
// cycle on o_result, marked by o_strobe, and the receiver cannot hold them off.
// On a miss, with or without a write-back of the victim, the victim and free frame
// search walks down the chain of POOL_FRAMES cells, one cell per cycle. A miss on a
// full pool with every page pinned ends in a KIND_FULL result.
// Flush-all scans every frame, one per cycle.

module lru_buffer_pool_frame_manager
    import lbpfm_pkg::*;
#(
    parameter int POOL_FRAMES    = 16,
    parameter int PIN_COUNT_BITS = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_req             i_req,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    output logic                  o_strobe,
    output t_result               o_result
);

    localparam int IW = $clog2(POOL_FRAMES);
    localparam int OW = $clog2(POOL_FRAMES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(POOL_FRAMES - 1);

    logic                      s_valid [POOL_FRAMES];
    logic [TABLE_W-1:0]        s_table [POOL_FRAMES];
    logic [PAGE_W-1:0]         s_page  [POOL_FRAMES];
    logic [PIN_COUNT_BITS-1:0] s_pin   [POOL_FRAMES];
    logic                      s_dirty [POOL_FRAMES];
    logic [IW-1:0]             s_rank  [POOL_FRAMES];
    logic                      s_hit   [POOL_FRAMES];

    logic          c_vf [POOL_FRAMES+1];
    logic [IW-1:0] c_vr [POOL_FRAMES+1];
    logic [IW-1:0] c_vi [POOL_FRAMES+1];
    logic          c_ff [POOL_FRAMES+1];
    logic [IW-1:0] c_fi [POOL_FRAMES+1];

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [CFG_W-1:0]  r_cfg;
    logic [OW-1:0]     r_occ, n_occ;
    logic [IW-1:0]     r_cnt, n_cnt;
    logic [IW-1:0]     r_load, n_load;
    logic [FRAME_W-1:0] r_done_frame, n_done_frame;
    logic              r_strobe, n_strobe;
    t_result           r_res, n_res;

    t_cell_op          op;
    logic [IW-1:0]     tgt;
    logic [IW-1:0]     rank_ref;
    logic              hit_any;
    logic [IW-1:0]     hit_idx;
    logic [OW-1:0]     limit;

    function automatic logic [FRAME_W-1:0] to_frame(input logic [IW-1:0] idx);
        logic [IW+FRAME_W-1:0] wide;
        wide = {{FRAME_W{1'b0}}, idx};
        return wide[FRAME_W-1:0];
    endfunction

    assign c_vf[0] = 1'b0;
    assign c_vr[0] = '0;
    assign c_vi[0] = '0;
    assign c_ff[0] = 1'b0;
    assign c_fi[0] = '0;

    for (genvar g = 0; g < POOL_FRAMES; g++) begin : g_cell
        lbpfm_cell #(
            .POOL_FRAMES    (POOL_FRAMES),
            .PIN_COUNT_BITS (PIN_COUNT_BITS),
            .ID             (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_op       (op),
            .i_tgt      (tgt),
            .i_rank_ref (rank_ref),
            .i_table    (r_req.req_table),
            .i_page     (r_req.req_page),
            .i_vf       (c_vf[g]),
            .i_vr       (c_vr[g]),
            .i_vi       (c_vi[g]),
            .i_ff       (c_ff[g]),
            .i_fi       (c_fi[g]),
            .o_vf       (c_vf[g+1]),
            .o_vr       (c_vr[g+1]),
            .o_vi       (c_vi[g+1]),
            .o_ff       (c_ff[g+1]),
            .o_fi       (c_fi[g+1]),
            .o_valid    (s_valid[g]),
            .o_table    (s_table[g]),
            .o_page     (s_page[g]),
            .o_pin      (s_pin[g]),
            .o_dirty    (s_dirty[g]),
            .o_rank     (s_rank[g]),
            .o_hit      (s_hit[g])
        );
    end

    // At most one cell matches, so an OR of the indexes encodes it.
    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < POOL_FRAMES; i++) begin
            if (s_hit[i]) begin
                hit_any = 1'b1;
                hit_idx = hit_idx | IW'(i);
            end
        end
    end

    always_comb begin
        if (r_cfg == '0) begin
            limit = OW'(1);
        end else if (32'(r_cfg) > POOL_FRAMES) begin
            limit = OW'(POOL_FRAMES);
        end else begin
            limit = OW'(r_cfg);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_occ        = r_occ;
        n_cnt        = r_cnt;
        n_load       = r_load;
        n_done_frame = r_done_frame;
        n_strobe     = 1'b0;
        n_res        = r_res;
        op           = '0;
        tgt          = hit_idx;
        rank_ref     = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_res.out_table = r_req.req_table;
                n_res.out_page  = r_req.req_page;
                n_res.frame     = to_frame(hit_idx);
                n_res.last      = 1'b1;
                n_state         = ST_IDLE;
                case (r_req.action)
                    ACT_FETCH: begin
                        if (hit_any) begin
                            op.inc_pin = 1'b1;
                            op.touch   = 1'b1;
                            rank_ref   = s_rank[hit_idx];
                            n_strobe   = 1'b1;
                            n_res.kind = KIND_HIT;
                        end else begin
                            n_cnt   = '0;
                            n_state = ST_SRCH;
                        end
                    end
                    ACT_FLUSH_ALL: begin
                        n_cnt   = '0;
                        n_state = ST_FLA;
                    end
                    default: begin
                        n_strobe = 1'b1;
                        if (!hit_any) begin
                            n_res.kind  = KIND_NOTRES;
                            n_res.frame = '0;
                        end else if (r_req.action == ACT_UNPIN) begin
                            op.dec_pin   = 1'b1;
                            op.set_dirty = r_req.mark_dirty && (s_pin[hit_idx] != '0);
                            n_res.kind   = KIND_DONE;
                        end else if (s_dirty[hit_idx]) begin
                            op.clr_dirty = 1'b1;
                            n_res.kind   = KIND_WB;
                            n_res.last   = 1'b0;
                            n_done_frame = to_frame(hit_idx);
                            n_state      = ST_DONE;
                        end else begin
                            n_res.kind = KIND_DONE;
                        end
                    end
                endcase
            end
            ST_SRCH: begin
                tgt = c_vi[POOL_FRAMES];
                if (r_cnt != LAST_IDX) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (r_occ >= limit) begin
                    if (!c_vf[POOL_FRAMES]) begin
                        n_strobe        = 1'b1;
                        n_res.kind      = KIND_FULL;
                        n_res.out_table = r_req.req_table;
                        n_res.out_page  = r_req.req_page;
                        n_res.frame     = '0;
                        n_res.last      = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        if (s_dirty[c_vi[POOL_FRAMES]]) begin
                            n_strobe        = 1'b1;
                            n_res.kind      = KIND_WB;
                            n_res.out_table = s_table[c_vi[POOL_FRAMES]];
                            n_res.out_page  = s_page[c_vi[POOL_FRAMES]];
                            n_res.frame     = to_frame(c_vi[POOL_FRAMES]);
                            n_res.last      = 1'b0;
                        end
                        op.drop  = 1'b1;
                        rank_ref = s_rank[c_vi[POOL_FRAMES]];
                        n_occ    = r_occ - 1'b1;
                        // The freed frame competes with any frame that was already free.
                        if (c_ff[POOL_FRAMES] && (c_fi[POOL_FRAMES] < c_vi[POOL_FRAMES])) begin
                            n_load = c_fi[POOL_FRAMES];
                        end else begin
                            n_load = c_vi[POOL_FRAMES];
                        end
                        n_state = ST_LOAD;
                    end
                end else begin
                    n_load  = c_fi[POOL_FRAMES];
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                tgt             = r_load;
                op.load         = 1'b1;
                op.touch        = 1'b1;
                rank_ref        = r_occ[IW-1:0];
                n_occ           = r_occ + 1'b1;
                n_strobe        = 1'b1;
                n_res.kind      = KIND_LOAD;
                n_res.out_table = r_req.req_table;
                n_res.out_page  = r_req.req_page;
                n_res.frame     = to_frame(r_load);
                n_res.last      = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_FLA: begin
                tgt = r_cnt;
                if (s_valid[r_cnt] && s_dirty[r_cnt]) begin
                    op.clr_dirty    = 1'b1;
                    n_strobe        = 1'b1;
                    n_res.kind      = KIND_WB;
                    n_res.out_table = s_table[r_cnt];
                    n_res.out_page  = s_page[r_cnt];
                    n_res.frame     = to_frame(r_cnt);
                    n_res.last      = 1'b0;
                end
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                n_strobe   = 1'b1;
                n_res.kind = KIND_DONE;
                n_res.last = 1'b1;
                if (r_req.action == ACT_FLUSH_ALL) begin
                    n_res.out_table = '0;
                    n_res.out_page  = '0;
                    n_res.frame     = '0;
                end else begin
                    n_res.out_table = r_req.req_table;
                    n_res.out_page  = r_req.req_page;
                    n_res.frame     = r_done_frame;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_occ    <= '0;
            r_strobe <= 1'b0;
            r_cfg    <= CFG_RESET;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_cnt        <= n_cnt;
        r_load       <= n_load;
        r_done_frame <= n_done_frame;
        r_res        <= n_res;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

`default_nettype wire

@@ rtl/lbpfm_checker.sv @@
// Port-level checks for the frame manager, bound to the top level.
`default_nettype none

module lbpfm_checker
    import lbpfm_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    o_strobe,
    input wire t_result o_result
);

    // An accepted request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    // A word that is not the last one leaves the request still in progress.
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy)
        else $error("non-final word while idle");

    // Only write-backs come before the final word of a request.
    a_only_wb_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> o_result.kind == KIND_WB)
        else $error("non-final word is not a write-back");

    // A write-back is never the final word.
    a_wb_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.kind == KIND_WB |-> !o_result.last)
        else $error("write-back marked last");

endmodule

bind lru_buffer_pool_frame_manager lbpfm_checker u_lbpfm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire
